@@ rtl/plfu_pkg.sv @@
package plfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 20;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int NUM_BITS   = $clog2(ENTRIES + 1);
  localparam int KEY_BITS   = 32;
  localparam int PC_BITS    = 16;
  // weight: 17-bit factor times a (COUNT_BITS+3)-bit signed difference, plus 33-bit term
  localparam int W_BITS     = COUNT_BITS + 3 + 17 + 2;

  localparam logic [1:0] ACT_ACCESS = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_PERIOD   = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] s1;
    logic [COUNT_BITS-1:0] s2;
    logic [COUNT_BITS-1:0] s3;
    logic [PC_BITS-1:0]    pc;
  } entry_t;

endpackage

@@ rtl/predictive_lfu_segment_cache_policy_unit.sv @@
// Flow from accept to done: an access compares one key per cycle over the used
// entries; an insert does the same, and when full it scans the weights (one weight per
// cycle), shifts out the victim and appends. A tick counts; a roll shifts all snapshots.
// Throughput: one request at a time; busy is high from start until done.
// Synchronous active-high reset empties the table, clears elapsed, capacity 16, period 1000.
// The result strobe done lasts one cycle; the receiver cannot stall.
module predictive_lfu_segment_cache_policy_unit
  import plfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] file_id,
  input  logic [15:0] seg_id,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic        evicted_valid,
  output logic [15:0] evicted_file,
  output logic [15:0] evicted_seg,
  output logic        period_rolled
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_ROLL   = 7'b0010000,
    S_APPEND = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  entry_t tbl [ENTRIES];
  logic [NUM_BITS-1:0] used;
  logic [4:0]  capacity;
  logic [15:0] period_ticks;
  logic [15:0] elapsed;
  logic [1:0]  act;
  logic [KEY_BITS-1:0] req_key;
  logic [NUM_BITS-1:0] ptr;
  logic [IDX_BITS-1:0] vic;
  logic signed [W_BITS-1:0] best;

  // effective capacity and period
  logic [NUM_BITS-1:0] cap_eff;
  logic [16:0] per_eff;
  logic [16:0] factor;
  always_comb begin
    if (capacity == 5'd0) cap_eff = NUM_BITS'(1);
    else if ({27'd0, capacity} > ENTRIES) cap_eff = NUM_BITS'(ENTRIES);
    else cap_eff = NUM_BITS'(capacity);
    per_eff = (period_ticks == 16'd0) ? 17'd1 : {1'b0, period_ticks};
    factor  = ({1'b0, elapsed} > per_eff) ? 17'd0 : per_eff - {1'b0, elapsed};
  end

  // shared weight unit on the entry at ptr
  logic [IDX_BITS-1:0] pi;
  entry_t cur;
  logic signed [COUNT_BITS+2:0] diff;
  logic signed [W_BITS-1:0] weight;
  assign pi  = ptr[IDX_BITS-1:0];
  assign cur = tbl[pi];
  always_comb begin
    diff = ($signed({3'b000, cur.s1}) <<< 1) - 3'sd3 * $signed({3'b000, cur.s2})
           + $signed({3'b000, cur.s3});
    weight = W_BITS'($signed({1'b0, factor}) * diff)
           + W_BITS'($signed({1'b0, per_eff}) * $signed({1'b0, cur.pc}));
  end

  logic roll_now;
  assign roll_now = ({1'b0, elapsed} + 17'd1) >= per_eff;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      capacity <= 5'd16;
      period_ticks <= 16'd1000;
      elapsed <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) capacity <= cfg_data[4:0];
        else period_ticks <= cfg_data;
      end
      unique case (state)
        // take request
        S_IDLE: if (start) begin
          act <= action;
          req_key <= {file_id, seg_id};
          ptr <= '0;
          status <= ST_OK;
          evicted_valid <= 1'b0;
          evicted_file <= '0;
          evicted_seg <= '0;
          period_rolled <= 1'b0;
          if (action == ACT_TICK) begin
            if (roll_now) begin
              elapsed <= '0;
              period_rolled <= 1'b1;
              state <= S_ROLL;
            end else begin
              elapsed <= elapsed + 16'd1;
              state <= S_DONE;
            end
          end else if (action == ACT_ACCESS || action == ACT_INSERT) begin
            state <= S_FIND;
          end else begin
            state <= S_DONE;
          end
        end
        // compare one key per cycle
        S_FIND: begin
          if (ptr == used) begin
            if (act == ACT_ACCESS) begin
              status <= ST_MISSING;
              state <= S_DONE;
            end else if (used >= cap_eff) begin
              ptr <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_APPEND;
            end
          end else if (cur.key == req_key) begin
            if (act == ACT_ACCESS) begin
              if (~&cur.total) tbl[pi].total <= cur.total + 1'b1;
              if (~&cur.pc) tbl[pi].pc <= cur.pc + 1'b1;
            end else begin
              status <= ST_PRESENT;
            end
            state <= S_DONE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        // find least weight, strict so oldest wins ties
        S_SCAN: begin
          if (ptr == used) begin
            evicted_valid <= 1'b1;
            evicted_file <= tbl[vic].key[31:16];
            evicted_seg <= tbl[vic].key[15:0];
            ptr <= {1'b0, vic};
            state <= S_SHIFT;
          end else begin
            if (ptr == '0 || weight < best) begin
              best <= weight;
              vic <= pi;
            end
            ptr <= ptr + 1'b1;
          end
        end
        // close the gap one slot per cycle
        S_SHIFT: begin
          if (ptr + 1'b1 >= used) begin
            used <= used - 1'b1;
            state <= S_APPEND;
          end else begin
            tbl[pi] <= tbl[IDX_BITS'(ptr + 1'b1)];
            ptr <= ptr + 1'b1;
          end
        end
        // roll snapshots one entry per cycle
        S_ROLL: begin
          if (ptr == used) begin
            state <= S_DONE;
          end else begin
            tbl[pi].s3 <= cur.s2;
            tbl[pi].s2 <= cur.s1;
            tbl[pi].s1 <= cur.total;
            tbl[pi].pc <= '0;
            ptr <= ptr + 1'b1;
          end
        end
        // append new entry at young end
        S_APPEND: begin
          if (used < NUM_BITS'(ENTRIES)) begin
            tbl[IDX_BITS'(used)] <= '{key: req_key, total: COUNT_BITS'(1), s1: '0,
                                      s2: '0, s3: '0, pc: PC_BITS'(1)};
            used <= used + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= NUM_BITS'(ENTRIES)) else $error("occupancy overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_evict_insert: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> (act == ACT_INSERT && status == ST_OK))
    else $error("eviction outside insert");
  a_roll_tick: assert property (@(posedge clk) disable iff (rst)
    (done && period_rolled) |-> act == ACT_TICK) else $error("roll outside tick");

endmodule
